### hdl/fbpw_pkg.sv
// Shared types, constants and codes for the framebuffer pixel writer.
package fbpw_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_DIM_DEF     = 256;
  localparam int STORE_BYTES_DEF = 16384;

  // Field and register widths.
  localparam int CFG_DIM_W    = 9;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_IDX_W    = 3;
  localparam int BPR_W        = 7;
  localparam int COORD_W      = 12;
  localparam int CALC_ADDR_W  = 18;
  localparam int OUT_ADDR_W   = 14;

  // Queue depths between the front, the back and the result port.
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Pixel masks, MSB first within a byte.
  localparam logic [7:0] ONE_BIT_MASK = 8'h80;
  localparam logic [7:0] TWO_BIT_MASK = 8'hC0;

  // Register reset values.
  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 9'd200;
  localparam logic [BPR_W-1:0]     BPR_RESET = 7'd25;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMORY_WIDTH   = 3'd0,
    CFG_MEMORY_HEIGHT  = 3'd1,
    CFG_LOGICAL_WIDTH  = 3'd2,
    CFG_LOGICAL_HEIGHT = 3'd3,
    CFG_ROTATION       = 3'd4,
    CFG_MIRRORING      = 3'd5,
    CFG_TWO_BIT_MODE   = 3'd6,
    CFG_BYTES_PER_ROW  = 3'd7
  } cfg_idx_e;

  // Write status codes.
  typedef enum logic [1:0] {
    ST_WRITTEN      = 2'd0,
    ST_LOGICAL_CLIP = 2'd1,
    ST_MEMORY_CLIP  = 2'd2
  } status_e;

  // Rotation codes.
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [CFG_DIM_W-1:0] memory_width;
    logic [CFG_DIM_W-1:0] memory_height;
    logic [CFG_DIM_W-1:0] logical_width;
    logic [CFG_DIM_W-1:0] logical_height;
    logic [1:0]           rotation;
    logic [1:0]           mirroring;
    logic                 two_bit_mode;
    logic [BPR_W-1:0]     bytes_per_row;
  } cfg_t;

  // One pixel write request.
  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
  } pixel_req_t;

  // One write result.
  typedef struct packed {
    logic [1:0]            write_status;
    logic [OUT_ADDR_W-1:0] byte_address;
    logic [7:0]            new_byte;
  } pixel_rsp_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    status_e                status;
    logic [CALC_ADDR_W-1:0] addr;
    logic [7:0]             mask;
    logic [7:0]             value;
  } wr_cmd_t;

endpackage

### hdl/framebuffer_pixel_writer.sv
// Top level of the framebuffer pixel writer: registers, front, queues and back.
//
// Requests are pixel writes (x, y, color) on req_i, taken when push is high and
// full is low. Each request gives exactly one result on rsp_o: a status, the
// byte address and the new byte value. A result waits while empty is low and
// is taken when pop is high. Results leave in request order.
// A request passes the front stage register, the command queue, the modify
// stage register of the back end and the result queue before its result can be popped.
// One request a cycle is sustained as long as results are taken each cycle;
// the rate is set by the single read-modify-write pass through the frame store,
// with the byte just written forwarded to a following request for the same byte.
// When pop stays low, the result queue fills, the back end stops issuing, the
// command queue fills and full rises; nothing is dropped.
// After reset the frame store is cleared one byte a cycle, through all of its
// StoreBytes bytes (16384 by default); full stays high meanwhile. Registers
// return to their reset values at once and may be written at any time the
// block has no request in flight.
module framebuffer_pixel_writer import fbpw_pkg::*; #(
  parameter int MaxDim     = MAX_DIM_DEF,
  parameter int StoreBytes = STORE_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  pixel_req_t            req_i,
  output logic                  empty,
  input  logic                  pop,
  output pixel_rsp_t            rsp_o
);

  cfg_t                 cfg_q;
  logic                 front_ready, in_valid;
  logic                 cmd_valid, cmd_ready;
  wr_cmd_t              cmd;
  logic                 mid_valid, mid_ready;
  wr_cmd_t              mid_cmd;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                 rsp_valid;
  pixel_rsp_t           rsp;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 clearing;
  logic                 out_ready;
  logic                 out_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.memory_width   <= DIM_RESET;
      cfg_q.memory_height  <= DIM_RESET;
      cfg_q.logical_width  <= DIM_RESET;
      cfg_q.logical_height <= DIM_RESET;
      cfg_q.rotation       <= ROT_0;
      cfg_q.mirroring      <= 2'b00;
      cfg_q.two_bit_mode   <= 1'b0;
      cfg_q.bytes_per_row  <= BPR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MEMORY_WIDTH:   cfg_q.memory_width   <= cfg_wdata_i;
        CFG_MEMORY_HEIGHT:  cfg_q.memory_height  <= cfg_wdata_i;
        CFG_LOGICAL_WIDTH:  cfg_q.logical_width  <= cfg_wdata_i;
        CFG_LOGICAL_HEIGHT: cfg_q.logical_height <= cfg_wdata_i;
        CFG_ROTATION:       cfg_q.rotation       <= cfg_wdata_i[1:0];
        CFG_MIRRORING:      cfg_q.mirroring      <= cfg_wdata_i[1:0];
        CFG_TWO_BIT_MODE:   cfg_q.two_bit_mode   <= cfg_wdata_i[0];
        CFG_BYTES_PER_ROW:  cfg_q.bytes_per_row  <= cfg_wdata_i[BPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Requests are held off during the clearing pass.
  assign full     = clearing || !front_ready;
  assign in_valid = push && !full;

  fbpw_front #(
    .MaxDim     (MaxDim),
    .StoreBytes (StoreBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid),
    .in_ready_o  (front_ready),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Command queue between front and back.
  fbpw_fifo #(
    .T     (wr_cmd_t),
    .Depth (MID_DEPTH)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_valid),
    .wr_ready_o (cmd_ready),
    .wr_data_i  (cmd),
    .rd_valid_o (mid_valid),
    .rd_ready_i (mid_ready),
    .rd_data_o  (mid_cmd),
    .count_o    (mid_count)
  );

  fbpw_back #(
    .StoreBytes (StoreBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (mid_valid),
    .cmd_ready_o (mid_ready),
    .cmd_i       (mid_cmd),
    .out_count_i (out_count),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .clearing_o  (clearing)
  );

  // Result queue toward the consumer.
  fbpw_fifo #(
    .T     (pixel_rsp_t),
    .Depth (OUT_DEPTH)
  ) u_rsp_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (rsp_valid),
    .wr_ready_o (out_ready),
    .wr_data_i  (rsp),
    .rd_valid_o (out_valid),
    .rd_ready_i (pop),
    .rd_data_o  (rsp_o),
    .count_o    (out_count)
  );

  assign empty = !out_valid;

  // The back end only sends a result when the result queue can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> out_ready)
    else $error("result lost at the result queue");

  // No request is taken while the store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_valid)
    else $error("request taken during the clearing pass");

  // A taken request is offered to the command queue in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid |=> cmd_valid)
    else $error("accepted request vanished in the front end");

  // The command queue refuses a command only when it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_ready |-> (int'(mid_count) == MID_DEPTH))
    else $error("command queue stalled while not full");

endmodule

### hdl/fbpw_fifo.sv
// Small flop-based queue used between the pipeline parts.
module fbpw_fifo import fbpw_pkg::*; #(
  parameter type T     = wr_cmd_t,
  parameter int  Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_valid_i,
  output logic                       wr_ready_o,
  input  T                           wr_data_i,
  output logic                       rd_valid_o,
  input  logic                       rd_ready_i,
  output T                           rd_data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T                store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = store_q[rd_ptr_q];
  assign count_o    = count_q;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hdl/fbpw_front.sv
// Front end: logical clip, rotation and mirroring, memory clip and address.
module fbpw_front import fbpw_pkg::*; #(
  parameter int MaxDim     = MAX_DIM_DEF,
  parameter int StoreBytes = STORE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pixel_req_t req_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output wr_cmd_t    cmd_o
);

  localparam int DimW = ($clog2(MaxDim + 1) > CFG_DIM_W) ? $clog2(MaxDim + 1) : CFG_DIM_W;

  // Sizes above the maximum dimension saturate.
  function automatic logic [CFG_DIM_W-1:0] dim_clamp(input logic [CFG_DIM_W-1:0] v);
    return (DimW'(v) > DimW'(MaxDim)) ? CFG_DIM_W'(MaxDim) : v;
  endfunction

  logic [CFG_DIM_W-1:0] w, h, lw, lh;
  logic signed [COORD_W-1:0] xs, ys, ws, hs, rx, ry, mx_d, my_d;
  logic lclip_d;

  logic                      s1_valid_q;
  logic                      s1_lclip_q;
  logic signed [COORD_W-1:0] s1_mx_q, s1_my_q;
  logic                      s1_color_nz_q;
  logic [1:0]                s1_color2_q;
  logic                      s1_load;

  logic                    mclip;
  logic [BPR_W-1:0]        col;
  logic [15:0]             row_off;
  logic [CALC_ADDR_W-1:0]  addr;
  logic                    addr_ok;
  logic [7:0]              mask, value;

  assign w  = dim_clamp(cfg_i.memory_width);
  assign h  = dim_clamp(cfg_i.memory_height);
  assign lw = dim_clamp(cfg_i.logical_width);
  assign lh = dim_clamp(cfg_i.logical_height);

  assign xs = signed'(COORD_W'(req_i.pixel_x));
  assign ys = signed'(COORD_W'(req_i.pixel_y));
  assign ws = signed'(COORD_W'(w));
  assign hs = signed'(COORD_W'(h));

  // Logical clip on the incoming request.
  assign lclip_d = ({1'b0, req_i.pixel_x} >= lw) || ({1'b0, req_i.pixel_y} >= lh);

  // Rotation into memory coordinates.
  always_comb begin
    unique case (rot_e'(cfg_i.rotation))
      ROT_0: begin
        rx = xs;
        ry = ys;
      end
      ROT_90: begin
        rx = ws - ys - 12'sd1;
        ry = xs;
      end
      ROT_180: begin
        rx = ws - xs - 12'sd1;
        ry = hs - ys - 12'sd1;
      end
      ROT_270: begin
        rx = ys;
        ry = hs - xs - 12'sd1;
      end
      default: begin
        rx = xs;
        ry = ys;
      end
    endcase
  end

  // Horizontal and vertical mirror.
  assign mx_d = cfg_i.mirroring[0] ? (ws - rx - 12'sd1) : rx;
  assign my_d = cfg_i.mirroring[1] ? (hs - ry - 12'sd1) : ry;

  // The first stage moves on when the command queue has room.
  assign in_ready_o = !s1_valid_q || cmd_ready_i;
  assign s1_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_lclip_q    <= lclip_d;
      s1_mx_q       <= mx_d;
      s1_my_q       <= my_d;
      s1_color_nz_q <= (req_i.pixel_color != '0);
      s1_color2_q   <= req_i.pixel_color[1:0];
    end
  end

  // Memory clip and byte address.
  assign mclip   = s1_mx_q[COORD_W-1] || s1_my_q[COORD_W-1] || (s1_mx_q >= ws) ||
                   (s1_my_q >= hs);
  assign col     = cfg_i.two_bit_mode ? s1_mx_q[8:2] : {1'b0, s1_mx_q[8:3]};
  assign row_off = 16'(s1_my_q[8:0]) * 16'(cfg_i.bytes_per_row);
  assign addr    = CALC_ADDR_W'(row_off) + CALC_ADDR_W'(col);
  assign addr_ok = (32'(addr) < 32'(StoreBytes));

  // Bit or slot mask and the bits that go into it.
  always_comb begin
    if (cfg_i.two_bit_mode) begin
      mask  = TWO_BIT_MASK >> {s1_mx_q[1:0], 1'b0};
      value = {s1_color2_q, 6'b0} >> {s1_mx_q[1:0], 1'b0};
    end else begin
      mask  = ONE_BIT_MASK >> s1_mx_q[2:0];
      value = s1_color_nz_q ? mask : 8'h00;
    end
  end

  // Classified command.
  always_comb begin
    cmd_o.mask  = mask;
    cmd_o.value = value;
    cmd_o.addr  = addr;
    if (s1_lclip_q) begin
      cmd_o.status = ST_LOGICAL_CLIP;
    end else if (mclip || !addr_ok) begin
      cmd_o.status = ST_MEMORY_CLIP;
    end else begin
      cmd_o.status = ST_WRITTEN;
    end
  end

  assign cmd_valid_o = s1_valid_q;

endmodule

### hdl/fbpw_back.sv
// Back end: frame store, clearing pass and read-modify-write with forwarding.
module fbpw_back import fbpw_pkg::*; #(
  parameter int StoreBytes = STORE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wr_cmd_t              cmd_i,
  input  logic [OUT_CNT_W-1:0] out_count_i,
  output logic                 rsp_valid_o,
  output pixel_rsp_t           rsp_o,
  output logic                 clearing_o
);

  localparam int AW = $clog2(StoreBytes);

  logic [7:0]    mem [StoreBytes];
  logic [7:0]    rdata_q;

  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  logic          credit_ok, issue;
  logic          b1_valid_q;
  wr_cmd_t       b1_cmd_q;
  logic [AW-1:0] b1_addr;

  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic [7:0]    fwd_data_q;

  logic [7:0]    old_byte, new_byte;
  logic          wr_en, mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // A command issues only when the result queue is sure to have room for it.
  assign credit_ok = ((OUT_CNT_W+1)'(out_count_i) + (OUT_CNT_W+1)'(b1_valid_q)) <
                     (OUT_CNT_W+1)'(OUT_DEPTH);
  assign cmd_ready_o = !clr_busy_q && credit_ok;
  assign issue       = cmd_valid_i && cmd_ready_o;
  assign clearing_o  = clr_busy_q;

  // Clearing pass after reset, one byte a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(StoreBytes - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Read stage: command moves into the modify stage with its byte read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_cmd_q <= cmd_i;
    end
  end

  // Modify stage: the previous write is forwarded when it hit the same byte.
  assign b1_addr  = b1_cmd_q.addr[AW-1:0];
  assign old_byte = (fwd_valid_q && (fwd_addr_q == b1_addr)) ? fwd_data_q : rdata_q;
  assign new_byte = (old_byte & ~b1_cmd_q.mask) | b1_cmd_q.value;
  assign wr_en    = b1_valid_q && (b1_cmd_q.status == ST_WRITTEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= b1_addr;
      fwd_data_q <= new_byte;
    end
  end

  // Write port is shared by the clearing pass and the modify stage.
  assign mem_we = clr_busy_q || wr_en;
  assign mem_wa = clr_busy_q ? clr_cnt_q : b1_addr;
  assign mem_wd = clr_busy_q ? 8'h00 : new_byte;

  // Frame store.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rdata_q <= mem[cmd_i.addr[AW-1:0]];
    end
  end

  // Result of the modify stage.
  always_comb begin
    rsp_o.write_status = b1_cmd_q.status;
    if (b1_cmd_q.status == ST_WRITTEN) begin
      rsp_o.byte_address = b1_cmd_q.addr[OUT_ADDR_W-1:0];
      rsp_o.new_byte     = new_byte;
    end else begin
      rsp_o.byte_address = '0;
      rsp_o.new_byte     = '0;
    end
  end

  assign rsp_valid_o = b1_valid_q;

  // A result never arrives at a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (out_count_i < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result arrived with the result queue full");

  // Nothing issues while the store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !issue)
    else $error("command issued during the clearing pass");

  // The clearing pass ends only after the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_cnt_q) == AW'(StoreBytes - 1)))
    else $error("clearing pass ended early");

  // A clipped request never touches the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_valid_q && (b1_cmd_q.status != ST_WRITTEN) && !clr_busy_q) |-> !mem_we)
    else $error("clipped request wrote the store");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the framebuffer pixel writer: directed and random pixel requests.
`timescale 1ns / 100ps

module tb;
  import fbpw_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_WAIT  = 8;

  // Mirroring register bits.
  localparam logic [1:0] MIRROR_H = 2'b01;
  localparam logic [1:0] MIRROR_V = 2'b10;

  // Patterns the result side cycles through when it is not holding off.
  typedef enum logic [1:0] {
    POP_EVERY,
    POP_COIN,
    POP_THIRD,
    POP_SPARSE
  } pop_pattern_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  logic                  full;
  pixel_req_t            req_i       = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  pixel_rsp_t            rsp_o;

  // Shadow copies of the register file and of the frame store.
  cfg_t       cfg_model;
  bit [7:0]   frame_shadow [STORE_BYTES_DEF];
  pixel_rsp_t pending_writes [$];
  pixel_req_t last_pixel = '0;

  int unsigned  error_count  = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  burst_left   = 0;
  bit           steady_push  = 1'b0;
  int unsigned  hold_asks    = 0;
  int unsigned  hold_seen    = 0;
  int unsigned  hold_left    = 0;
  int unsigned  pattern_left = 0;
  int unsigned  pop_tick     = 0;
  pop_pattern_e pop_pattern  = POP_EVERY;

  framebuffer_pixel_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Size registers above the largest dimension behave as the largest dimension.
  function automatic int dim_limit(logic [CFG_DIM_W-1:0] v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
  endfunction

  // Works out the result of one pixel request and updates the shadow frame store.
  function automatic pixel_rsp_t apply_pixel_write(pixel_req_t p);
    int         w, h, lw, lh, px, py, mx, my, addr, sh;
    logic [7:0] old_byte, mask, bits, new_val;
    pixel_rsp_t r;
    w  = dim_limit(cfg_model.memory_width);
    h  = dim_limit(cfg_model.memory_height);
    lw = dim_limit(cfg_model.logical_width);
    lh = dim_limit(cfg_model.logical_height);
    px = int'(p.pixel_x);
    py = int'(p.pixel_y);
    r  = '0;
    if (px >= lw || py >= lh) begin
      r.write_status = ST_LOGICAL_CLIP;
      return r;
    end
    case (rot_e'(cfg_model.rotation))
      ROT_0: begin
        mx = px;
        my = py;
      end
      ROT_90: begin
        mx = w - py - 1;
        my = px;
      end
      ROT_180: begin
        mx = w - px - 1;
        my = h - py - 1;
      end
      default: begin
        mx = py;
        my = h - px - 1;
      end
    endcase
    if ((cfg_model.mirroring & MIRROR_H) != 0) mx = w - mx - 1;
    if ((cfg_model.mirroring & MIRROR_V) != 0) my = h - my - 1;
    if (mx < 0 || my < 0 || mx >= w || my >= h) begin
      r.write_status = ST_MEMORY_CLIP;
      return r;
    end
    if (cfg_model.two_bit_mode) addr = mx / 4 + my * int'(cfg_model.bytes_per_row);
    else addr = mx / 8 + my * int'(cfg_model.bytes_per_row);
    if (addr >= STORE_BYTES_DEF) begin
      r.write_status = ST_MEMORY_CLIP;
      return r;
    end
    old_byte = frame_shadow[addr];
    if (cfg_model.two_bit_mode) begin
      sh      = (mx % 4) * 2;
      mask    = TWO_BIT_MASK >> sh;
      bits    = {p.pixel_color[1:0], 6'b0} >> sh;
      new_val = (old_byte & ~mask) | bits;
    end else begin
      mask    = ONE_BIT_MASK >> (mx % 8);
      new_val = (p.pixel_color == '0) ? (old_byte & ~mask) : (old_byte | mask);
    end
    frame_shadow[addr] = new_val;
    r.write_status = ST_WRITTEN;
    r.byte_address = addr[OUT_ADDR_W-1:0];
    r.new_byte     = new_val;
    return r;
  endfunction

  function automatic cfg_t build_cfg(int mw, int mh, int lw, int lh, int rot, int mir,
                                     int two_bit, int bpr);
    cfg_t c;
    c.memory_width   = CFG_DIM_W'(mw);
    c.memory_height  = CFG_DIM_W'(mh);
    c.logical_width  = CFG_DIM_W'(lw);
    c.logical_height = CFG_DIM_W'(lh);
    c.rotation       = 2'(rot);
    c.mirroring      = 2'(mir);
    c.two_bit_mode   = 1'(two_bit);
    c.bytes_per_row  = BPR_W'(bpr);
    return c;
  endfunction

  function automatic pixel_req_t pixel_at(int x, int y, int color);
    pixel_req_t p;
    p.pixel_x     = 8'(x);
    p.pixel_y     = 8'(y);
    p.pixel_color = 16'(color);
    return p;
  endfunction

  // Mostly sensible sizes, now and then zero or above the largest dimension.
  function automatic int random_dim();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick <= 2) return $urandom_range(MAX_DIM_DEF + 1, 511);
    return $urandom_range(1, MAX_DIM_DEF);
  endfunction

  // Random setting in which the logical size usually matches the rotated memory size.
  function automatic cfg_t random_cfg();
    cfg_t c;
    int   ppb, bpr;
    c.two_bit_mode  = 1'($urandom_range(0, 1));
    c.rotation      = 2'($urandom_range(0, 3));
    c.mirroring     = 2'($urandom_range(0, 3));
    c.memory_width  = CFG_DIM_W'(random_dim());
    c.memory_height = CFG_DIM_W'(random_dim());
    if (c.rotation == ROT_90 || c.rotation == ROT_270) begin
      c.logical_width  = c.memory_height;
      c.logical_height = c.memory_width;
    end else begin
      c.logical_width  = c.memory_width;
      c.logical_height = c.memory_height;
    end
    if ($urandom_range(0, 3) == 0) c.logical_width = CFG_DIM_W'($urandom_range(0, 511));
    if ($urandom_range(0, 3) == 0) c.logical_height = CFG_DIM_W'($urandom_range(0, 511));
    ppb = c.two_bit_mode ? 4 : 8;
    bpr = (dim_limit(c.memory_width) + ppb - 1) / ppb;
    if (bpr < 1) bpr = 1;
    if ($urandom_range(0, 4) == 0) bpr = $urandom_range(1, 127);
    c.bytes_per_row = BPR_W'(bpr);
    return c;
  endfunction

  // Random request: mostly inside the logical area, some near the last one to hit the
  // same byte back to back, the rest anywhere.
  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    int         lw, lh, pick;
    lw   = dim_limit(cfg_model.logical_width);
    lh   = dim_limit(cfg_model.logical_height);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      p.pixel_x = last_pixel.pixel_x ^ 8'($urandom_range(0, 3));
      p.pixel_y = last_pixel.pixel_y;
    end else if (pick < 8 && lw > 0 && lh > 0) begin
      p.pixel_x = 8'($urandom_range(0, lw - 1));
      p.pixel_y = 8'($urandom_range(0, lh - 1));
    end else begin
      p.pixel_x = 8'($urandom_range(0, 255));
      p.pixel_y = 8'($urandom_range(0, 255));
    end
    if (!cfg_model.two_bit_mode && $urandom_range(0, 2) == 0) p.pixel_color = '0;
    else p.pixel_color = 16'($urandom_range(0, 65535));
    last_pixel = p;
    return p;
  endfunction

  // Sends one request in bursts with random gaps; push is left high on return.
  task automatic send_pixel(pixel_req_t p);
    int gap;
    if (!steady_push && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    push  <= 1'b1;
    req_i <= p;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_writes.push_back(apply_pixel_write(p));
  endtask

  // Waits until every request has its result, then writes all registers.
  task automatic reconfigure(cfg_t c);
    cfg_idx_e idx;
    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_MEMORY_WIDTH:   cfg_wdata_i <= c.memory_width;
        CFG_MEMORY_HEIGHT:  cfg_wdata_i <= c.memory_height;
        CFG_LOGICAL_WIDTH:  cfg_wdata_i <= c.logical_width;
        CFG_LOGICAL_HEIGHT: cfg_wdata_i <= c.logical_height;
        CFG_ROTATION:       cfg_wdata_i <= CFG_DATA_W'(c.rotation);
        CFG_MIRRORING:      cfg_wdata_i <= CFG_DATA_W'(c.mirroring);
        CFG_TWO_BIT_MODE:   cfg_wdata_i <= CFG_DATA_W'(c.two_bit_mode);
        default:            cfg_wdata_i <= CFG_DATA_W'(c.bytes_per_row);
      endcase
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= idx;
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    cfg_model = c;
  endtask

  // Reset settings: corners of the area, clip just past it, set and clear in one byte.
  task automatic test_default_extremes();
    reconfigure(build_cfg(200, 200, 200, 200, ROT_0, 0, 0, 25));
    send_pixel(pixel_at(0, 0, 16'h0001));
    send_pixel(pixel_at(7, 0, 16'hFFFF));
    send_pixel(pixel_at(0, 0, 16'h0000));
    send_pixel(pixel_at(199, 199, 16'h8000));
    send_pixel(pixel_at(200, 0, 16'h0001));
    send_pixel(pixel_at(0, 200, 16'h0001));
    send_pixel(pixel_at(255, 255, 16'h0001));
  endtask

  // Saturated and zero sizes, and addresses at and past the end of the store.
  task automatic test_dimension_limits();
    reconfigure(build_cfg(511, 511, 511, 511, ROT_0, 0, 0, 32));
    send_pixel(pixel_at(255, 255, 16'h0001));
    send_pixel(pixel_at(128, 0, 16'hAAAA));
    reconfigure(build_cfg(0, 256, 256, 256, ROT_0, 0, 0, 1));
    send_pixel(pixel_at(5, 5, 16'h0001));
    reconfigure(build_cfg(256, 256, 256, 0, ROT_0, 0, 0, 32));
    send_pixel(pixel_at(0, 0, 16'h0001));
    reconfigure(build_cfg(256, 256, 256, 256, ROT_0, 0, 1, 127));
    send_pixel(pixel_at(0, 200, 16'h0003));
    send_pixel(pixel_at(255, 128, 16'h0002));
    send_pixel(pixel_at(0, 129, 16'h0001));
    send_pixel(pixel_at(1, 129, 16'h0003));
    send_pixel(pixel_at(4, 129, 16'h0002));
  endtask

  // Each rotation once, paired with each mirroring setting, on a non-square store.
  task automatic test_orientations();
    for (int r = 0; r < 4; r++) begin
      if (r % 2 == 1) reconfigure(build_cfg(40, 24, 24, 40, r, r, 0, 5));
      else reconfigure(build_cfg(40, 24, 40, 24, r, r, 0, 5));
      send_pixel(pixel_at(3, 5, 16'h0001));
    end
  endtask

  // Random settings, each followed by a run of random requests.
  task automatic test_random_mix();
    for (int phase = 0; phase < 11; phase++) begin
      reconfigure(random_cfg());
      for (int n = 0; n < 40; n++) send_pixel(random_pixel());
    end
  endtask

  // The result side holds off while requests keep coming, so the block fills and stalls.
  task automatic test_result_backpressure();
    reconfigure(build_cfg(256, 256, 256, 256, $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 1), 64));
    steady_push = 1'b1;
    hold_asks++;
    for (int n = 0; n < 40; n++) send_pixel(random_pixel());
    steady_push = 1'b0;
  endtask

  // Result side: a long hold-off when asked, otherwise a changing stall pattern.
  always @(posedge clk_i) begin : result_taker
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    pop_tick++;
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pop_pattern  = pop_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 128);
      end
      pattern_left--;
      case (pop_pattern)
        POP_EVERY: pop <= 1'b1;
        POP_COIN:  pop <= 1'($urandom_range(0, 1));
        POP_THIRD: pop <= (pop_tick % 3 == 0);
        default:   pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    pixel_rsp_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_writes.size() == 0) begin
        $error("result with no request waiting: status %0d address %0d byte 0x%02h",
               rsp_o.write_status, rsp_o.byte_address, rsp_o.new_byte);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        if (rsp_o.write_status !== want.write_status) begin
          $error("write_status: expected %0d, actual %0d", want.write_status,
                 rsp_o.write_status);
          error_count++;
        end
        if (rsp_o.byte_address !== want.byte_address) begin
          $error("byte_address: expected %0d, actual %0d", want.byte_address,
                 rsp_o.byte_address);
          error_count++;
        end
        if (rsp_o.new_byte !== want.new_byte) begin
          $error("new_byte: expected 0x%02h, actual 0x%02h", want.new_byte, rsp_o.new_byte);
          error_count++;
        end
      end
    end
  end

  // Ends a run that hangs; the limit covers the store clear after reset.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[framebuffer_pixel_writer] ERROR");
    $finish;
  end

  // Reset, the tests in turn, then drain and report.
  initial begin : test_sequence
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_extremes();
    test_dimension_limits();
    test_orientations();
    test_random_mix();
    test_result_backpressure();
    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[framebuffer_pixel_writer] OK");
    end else begin
      $display("[framebuffer_pixel_writer] ERROR");
    end
    $finish;
  end

endmodule
